// ===== rtl/dlps_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the DDA line pattern stepper.
package dlps_pkg;

  // Kind of an input item, carried on in_tuser
  typedef enum logic {
    ACT_START = 1'b0,
    ACT_STEP  = 1'b1
  } action_t;

  // Stroke pattern codes; the unused codes draw solid
  typedef enum logic [2:0] {
    PAT_SOLID            = 3'd0,
    PAT_POINT            = 3'd1,
    PAT_DASH             = 3'd2,
    PAT_DASH_POINT       = 3'd3,
    PAT_DASH_POINT_POINT = 3'd4
  } pattern_t;

  typedef enum logic {
    BK_IDLE,
    BK_DIV
  } back_state_t;

  // Status of one iterative divider
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  localparam int PAT_W   = 3;
  localparam int COLOR_W = 4;

  // Dash period is 8 steps (low three bits of the step number);
  // dash-point repeats every 6 steps, tracked by a wrapping counter.
  localparam int         DASH_BITS    = 3;
  localparam logic [2:0] DP_WRAP_LAST = 3'd5;

endpackage

// ===== rtl/dlps_div.sv =====
`timescale 1ns / 1ps
// Bit-serial restoring divider: (span << FRAC_BITS) / divisor, span <= divisor.
module dlps_div #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [COORD_BITS-1:0]     span,
  input  logic [COORD_BITS-1:0]     divisor,
  output dlps_pkg::div_status_t     status,
  output logic [FRAC_BITS:0]        quotient
);
  import dlps_pkg::*;

  localparam int QW    = COORD_BITS + FRAC_BITS;
  localparam int CNT_W = $clog2(QW);
  localparam int LAST  = QW - 1;

  logic [COORD_BITS-1:0] rem_r, rem_nxt;
  logic [QW-1:0]         quo_r, quo_nxt;
  logic [COORD_BITS-1:0] div_r, div_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [COORD_BITS:0]   shifted;
  logic [COORD_BITS:0]   diff;
  logic                  ge;

  always_comb begin
    shifted  = {rem_r, quo_r[QW-1]};
    diff     = shifted - {1'b0, div_r};
    ge       = (shifted >= {1'b0, div_r});
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    div_nxt  = div_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = {span, {FRAC_BITS{1'b0}}};
      div_nxt  = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // one quotient bit per cycle
      rem_nxt = ge ? diff[COORD_BITS-1:0] : shifted[COORD_BITS-1:0];
      quo_nxt = {quo_r[QW-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(LAST)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    div_r <= div_nxt;
    cnt_r <= cnt_nxt;
  end

  assign status.busy = busy_r;
  assign status.done = done_r;
  assign quotient    = quo_r[FRAC_BITS:0];

endmodule

// ===== rtl/dlps_front.sv =====
`timescale 1ns / 1ps
// Input side: accept items, precompute spans and step count, queue commands.
module dlps_front #(
  parameter int  COORD_BITS = 12,
  localparam int IN_DW      = ((4 * COORD_BITS + 7 + 7) / 8) * 8,
  localparam int ENTRY_W    = 5 * COORD_BITS + 10
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [IN_DW-1:0]   in_tdata,
  input  logic               in_tuser,
  output logic               cmd_valid,
  input  logic               cmd_ready,
  output logic [ENTRY_W-1:0] cmd_data
);
  import dlps_pkg::*;

  localparam int C = COORD_BITS;

  logic [C-1:0]       x1, y1, x2, y2, dx, dy, count;
  logic [PAT_W-1:0]   pat;
  logic [COLOR_W-1:0] col;
  logic               x_neg, y_neg;
  action_t            kind;
  logic [ENTRY_W-1:0] entry;

  logic [ENTRY_W-1:0] mem_r [2];
  logic               wr_ptr_r, rd_ptr_r;
  logic [1:0]         fill_r;
  logic               push, pop;

  // classify and take the spans apart
  always_comb begin
    x1    = in_tdata[C-1:0];
    y1    = in_tdata[2*C-1:C];
    x2    = in_tdata[3*C-1:2*C];
    y2    = in_tdata[4*C-1:3*C];
    pat   = in_tdata[4*C+PAT_W-1:4*C];
    col   = in_tdata[4*C+PAT_W+COLOR_W-1:4*C+PAT_W];
    kind  = action_t'(in_tuser);
    x_neg = (x2 < x1);
    y_neg = (y2 < y1);
    dx    = x_neg ? (x1 - x2) : (x2 - x1);
    dy    = y_neg ? (y1 - y2) : (y2 - y1);
    count = (dx >= dy) ? dx : dy;
    entry = {col, pat, count, y_neg, x_neg, dy, dx, y1, x1, kind};
  end

  assign in_tready = (fill_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign cmd_valid = (fill_r != 2'd0);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd_data  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      fill_r <= fill_r + {1'b0, push} - {1'b0, pop};
    end
    if (push) mem_r[wr_ptr_r] <= entry;
  end

endmodule

// ===== rtl/dlps_back.sv =====
`timescale 1ns / 1ps
// Execution side: line state, divider control, pattern and output register.
module dlps_back #(
  parameter int  COORD_BITS = 12,
  parameter int  FRAC_BITS  = 16,
  localparam int ENTRY_W    = 5 * COORD_BITS + 10,
  localparam int OUT_DW     = ((2 * COORD_BITS + 5 + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cmd_valid,
  output logic                  cmd_ready,
  input  logic [ENTRY_W-1:0]    cmd_data,
  output logic                  div_start,
  output logic [COORD_BITS-1:0] div_x_span,
  output logic [COORD_BITS-1:0] div_y_span,
  output logic [COORD_BITS-1:0] div_count,
  input  dlps_pkg::div_status_t x_stat,
  input  dlps_pkg::div_status_t y_stat,
  input  logic [FRAC_BITS:0]    x_quot,
  input  logic [FRAC_BITS:0]    y_quot,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DW-1:0]     out_tdata,
  output logic                  out_tlast,
  output logic                  out_tuser
);
  import dlps_pkg::*;

  localparam int C   = COORD_BITS;
  localparam int AW  = COORD_BITS + FRAC_BITS;
  localparam int IW  = FRAC_BITS + 2;
  localparam int PKW = 2 * C + COLOR_W + 1;

  // command fields
  logic               c_kind_bit;
  logic [C-1:0]       c_x1, c_y1, c_dx, c_dy, c_count;
  logic               c_x_neg, c_y_neg;
  logic [PAT_W-1:0]   c_pat;
  logic [COLOR_W-1:0] c_col;

  back_state_t        state_r, state_nxt;
  logic [AW-1:0]      x_acc_r, x_acc_nxt, y_acc_r, y_acc_nxt;
  logic [IW-1:0]      x_inc_r, x_inc_nxt, y_inc_r, y_inc_nxt;
  logic [C:0]         step_idx_r, step_idx_nxt, step_tot_r, step_tot_nxt;
  logic [2:0]         wrap6_r, wrap6_nxt;
  pattern_t           pat_r, pat_nxt;
  logic [COLOR_W-1:0] color_r, color_nxt;
  logic               active_r, active_nxt;
  logic               x_neg_r, x_neg_nxt, y_neg_r, y_neg_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [PKW-1:0]     out_data_r, out_data_nxt;
  logic               out_last_r, out_last_nxt;
  logic               out_noline_r, out_noline_nxt;

  logic               out_free, start_pop, step_pop, plot, last;
  logic [C:0]         n;
  logic [2:0]         wrap6_inc;
  logic [IW-1:0]      x_inc_new, y_inc_new;

  assign {c_col, c_pat, c_count, c_y_neg, c_x_neg, c_dy, c_dx, c_y1, c_x1, c_kind_bit} =
    cmd_data;

  assign div_x_span = c_dx;
  assign div_y_span = c_dy;
  assign div_count  = c_count;

  always_comb begin
    out_free  = !out_valid_r || out_tready;
    cmd_ready = (state_r == BK_IDLE) &&
                ((action_t'(c_kind_bit) == ACT_START) || out_free);
    start_pop = cmd_valid && cmd_ready && (action_t'(c_kind_bit) == ACT_START);
    step_pop  = cmd_valid && cmd_ready && (action_t'(c_kind_bit) == ACT_STEP);
    div_start = start_pop && (c_count != '0);

    n         = step_idx_r + 1'b1;
    last      = (n == step_tot_r);
    wrap6_inc = (wrap6_r == DP_WRAP_LAST) ? 3'd0 : wrap6_r + 3'd1;

    case (pat_r)
      PAT_POINT:            plot = n[0];
      PAT_DASH:             plot = (n[DASH_BITS-1:0] != '0);
      PAT_DASH_POINT:       plot = n[0] || (wrap6_inc == 3'd0);
      PAT_DASH_POINT_POINT: plot = n[0] || (n[DASH_BITS-1:0] == '0);
      default:              plot = 1'b1;
    endcase

    x_inc_new = x_neg_r ? (IW'(0) - {1'b0, x_quot}) : {1'b0, x_quot};
    y_inc_new = y_neg_r ? (IW'(0) - {1'b0, y_quot}) : {1'b0, y_quot};

    state_nxt      = state_r;
    x_acc_nxt      = x_acc_r;
    y_acc_nxt      = y_acc_r;
    x_inc_nxt      = x_inc_r;
    y_inc_nxt      = y_inc_r;
    step_idx_nxt   = step_idx_r;
    step_tot_nxt   = step_tot_r;
    wrap6_nxt      = wrap6_r;
    pat_nxt        = pat_r;
    color_nxt      = color_r;
    active_nxt     = active_r;
    x_neg_nxt      = x_neg_r;
    y_neg_nxt      = y_neg_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_data_nxt   = out_data_r;
    out_last_nxt   = out_last_r;
    out_noline_nxt = out_noline_r;

    case (state_r)
      BK_IDLE: begin
        if (start_pop) begin
          // latch the new line; increments follow from the dividers
          x_acc_nxt    = {c_x1, {FRAC_BITS{1'b0}}};
          y_acc_nxt    = {c_y1, {FRAC_BITS{1'b0}}};
          pat_nxt      = pattern_t'(c_pat);
          color_nxt    = c_col;
          step_idx_nxt = '0;
          step_tot_nxt = {1'b0, c_count};
          wrap6_nxt    = 3'd0;
          active_nxt   = 1'b0;
          x_neg_nxt    = c_x_neg;
          y_neg_nxt    = c_y_neg;
          x_inc_nxt    = '0;
          y_inc_nxt    = '0;
          if (c_count != '0) state_nxt = BK_DIV;
        end else if (step_pop) begin
          out_valid_nxt = 1'b1;
          if (!active_r) begin
            out_data_nxt   = '0;
            out_last_nxt   = 1'b0;
            out_noline_nxt = 1'b1;
          end else begin
            out_data_nxt   = {plot, color_r, y_acc_r[AW-1:FRAC_BITS], x_acc_r[AW-1:FRAC_BITS]};
            out_last_nxt   = last;
            out_noline_nxt = 1'b0;
            // advance the accumulators
            x_acc_nxt      = x_acc_r + {{(AW-IW){x_inc_r[IW-1]}}, x_inc_r};
            y_acc_nxt      = y_acc_r + {{(AW-IW){y_inc_r[IW-1]}}, y_inc_r};
            step_idx_nxt   = n;
            wrap6_nxt      = wrap6_inc;
            if (last || (n >= step_tot_r)) active_nxt = 1'b0;
          end
        end
      end
      BK_DIV: begin
        if (x_stat.done && y_stat.done) begin
          x_inc_nxt  = x_inc_new;
          y_inc_nxt  = y_inc_new;
          active_nxt = 1'b1;
          state_nxt  = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
    end
    x_acc_r      <= x_acc_nxt;
    y_acc_r      <= y_acc_nxt;
    x_inc_r      <= x_inc_nxt;
    y_inc_r      <= y_inc_nxt;
    step_idx_r   <= step_idx_nxt;
    step_tot_r   <= step_tot_nxt;
    wrap6_r      <= wrap6_nxt;
    pat_r        <= pat_nxt;
    color_r      <= color_nxt;
    x_neg_r      <= x_neg_nxt;
    y_neg_r      <= y_neg_nxt;
    out_data_r   <= out_data_nxt;
    out_last_r   <= out_last_nxt;
    out_noline_r <= out_noline_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DW-PKW){1'b0}}, out_data_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_noline_r;

endmodule

// ===== rtl/dda_line_pattern_stepper.sv =====
`timescale 1ns / 1ps
// Top level of the DDA line rasterizer with stroke patterns.
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+-----------------------------------------
//  in_     | in  | in_tvalid / in_tready | tdata endpoints, pattern, color; tuser kind
//  out_    | out | out_tvalid/out_tready | tdata pixel, color, plot; tlast; tuser
//
//  Step items: one pixel per cycle in the back end while out_ is ready and it is idle.
//  Start with a nonzero span: the back end waits in BK_DIV while the two bit-serial
//  restoring dividers run side by side.
//  Zero-length start: no division. A two-entry command queue sits between the sides.
//  Reset (rst_n low, synchronous) empties the queue, idles the dividers, drops the line.
//  A stalled out_ holds its result; the queue keeps taking items until it fills.
module dda_line_pattern_stepper #(
  parameter int  COORD_BITS = 12,
  parameter int  FRAC_BITS  = 16,
  localparam int IN_DW      = ((4 * COORD_BITS + 7 + 7) / 8) * 8,
  localparam int OUT_DW     = ((2 * COORD_BITS + 5 + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  // x_start, y_start, x_end, y_end (COORD_BITS each), pattern (3), pixel_color (4)
  input  logic [IN_DW-1:0]  in_tdata,
  // action: 0 start a line, 1 step
  input  logic              in_tuser,
  output logic              out_tvalid,
  input  logic              out_tready,
  // pixel_x, pixel_y (COORD_BITS each), color_out (4), plot (1)
  output logic [OUT_DW-1:0] out_tdata,
  // last_pixel
  output logic              out_tlast,
  // no_line
  output logic              out_tuser
);
  import dlps_pkg::*;

  localparam int ENTRY_W = 5 * COORD_BITS + 10;

  logic                  cmd_valid, cmd_ready;
  logic [ENTRY_W-1:0]    cmd_data;
  logic                  div_start;
  logic [COORD_BITS-1:0] div_x_span, div_y_span, div_count;
  div_status_t           x_stat, y_stat;
  logic [FRAC_BITS:0]    x_quot, y_quot;

  // Front: accept, classify, precompute spans, queue
  dlps_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd_data  (cmd_data)
  );

  // Per-axis increment dividers; both start together and finish together
  dlps_div #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_div_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .span     (div_x_span),
    .divisor  (div_count),
    .status   (x_stat),
    .quotient (x_quot)
  );

  dlps_div #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_div_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .span     (div_y_span),
    .divisor  (div_count),
    .status   (y_stat),
    .quotient (y_quot)
  );

  // Back: line state, pattern, output register
  dlps_back #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd_data   (cmd_data),
    .div_start  (div_start),
    .div_x_span (div_x_span),
    .div_y_span (div_y_span),
    .div_count  (div_count),
    .x_stat     (x_stat),
    .y_stat     (y_stat),
    .x_quot     (x_quot),
    .y_quot     (y_quot),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  // The two dividers run in lockstep
  a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    (x_stat == y_stat))
    else $error("axis dividers out of step");

  // A divider is never restarted while it is still busy
  a_div_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    x_stat.busy |-> !div_start)
    else $error("divider restarted mid-operation");

  // A no-line result carries an all-zero pixel and no last flag
  a_noline_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> ((out_tdata == '0) && !out_tlast))
    else $error("no-line result with nonzero payload");

  // Nothing leaves the queue while the increments are being computed
  a_hold_during_div: assert property (@(posedge clk) disable iff (!rst_n)
    x_stat.busy |-> !cmd_ready)
    else $error("command taken during division");

endmodule
